@@ hdl/rtcdu_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rtcdu_pkg
// Shared sizes, types and codes of the row table with cursor, cut and restore.
// ----------------------------------------------------------------------------
package rtcdu_pkg;

    // table size and derived widths
    localparam int MAX_ROWS = 1024;
    localparam int ROW_W    = $clog2(MAX_ROWS);
    localparam int LINK_W   = ROW_W + 1;
    localparam int ACTION_W = 3;
    localparam int DIST_W   = 10;
    localparam int CFG_W    = LINK_W;

    // stream payload widths, padded to whole bytes
    localparam int S_DATA_W = ((DIST_W + ROW_W + 7) / 8) * 8;
    localparam int M_DATA_W = ((ROW_W + 1 + 7) / 8) * 8;

    typedef logic [ROW_W-1:0]  row_t;
    typedef logic [LINK_W-1:0] link_t;

    // link value meaning no neighbor
    localparam link_t NO_ROW = link_t'(MAX_ROWS);

    // action codes
    localparam logic [ACTION_W-1:0] ACT_INIT    = 3'd0;
    localparam logic [ACTION_W-1:0] ACT_UP      = 3'd1;
    localparam logic [ACTION_W-1:0] ACT_DOWN    = 3'd2;
    localparam logic [ACTION_W-1:0] ACT_CUT     = 3'd3;
    localparam logic [ACTION_W-1:0] ACT_RESTORE = 3'd4;
    localparam logic [ACTION_W-1:0] ACT_QUERY   = 3'd5;

    // configuration register indexes
    localparam logic CFG_ROW_COUNT = 1'b0;
    localparam logic CFG_START_ROW = 1'b1;

endpackage

@@ hdl/rtcdu_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rtcdu_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module rtcdu_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

@@ hdl/row_table_cursor_delete_undo.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// row_table_cursor_delete_undo
// Row table kept as a doubly linked list in RAM, with a cursor and a stack
// of cut rows that restore takes back in reverse order.
// ----------------------------------------------------------------------------
// One transaction in gives one transaction out. Actions run one at a time
// and the block takes the next one while a result still waits on the output.
// Init writes one row of links per cycle. Up and down walk one link per
// cycle through the registered read of the link RAMs; a walk that runs off
// the table stops early with an error, and a zero distance walks no link.
// Restore reads the stack, then the links of the popped row. Actions
// refused before any walk or write report error and change nothing. Rows
// are only valid after a successful init; before it every query reads as
// not present.
// ----------------------------------------------------------------------------
module row_table_cursor_delete_undo (
    input  logic                             clk,
    input  logic                             rst_n,
    // configuration write port
    input  logic                             cfg_wr_en,
    input  logic                             cfg_addr,
    input  logic [rtcdu_pkg::CFG_W-1:0]      cfg_wdata,
    // action stream
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // move_distance [9:0], query_row [19:10], zero pad
    input  logic [rtcdu_pkg::S_DATA_W-1:0]   s_tdata,
    // action [2:0]
    input  logic [rtcdu_pkg::ACTION_W-1:0]   s_tuser,
    // result stream
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // cursor_row [9:0], row_present [10], zero pad
    output logic [rtcdu_pkg::M_DATA_W-1:0]   m_tdata,
    // error [0]
    output logic                             m_tuser
);

    import rtcdu_pkg::*;

    // sequencer states
    localparam logic [2:0] ST_IDLE    = 3'd0;
    localparam logic [2:0] ST_INIT    = 3'd1;
    localparam logic [2:0] ST_MOVE    = 3'd2;
    localparam logic [2:0] ST_CUT     = 3'd3;
    localparam logic [2:0] ST_RST_STK = 3'd4;
    localparam logic [2:0] ST_RST_LNK = 3'd5;
    localparam logic [2:0] ST_QUERY   = 3'd6;
    localparam logic [2:0] ST_OUT     = 3'd7;

    logic [2:0]        state_reg, state_next;
    link_t             row_count_reg;
    row_t              start_row_reg;
    row_t              cursor_reg, cursor_next;
    link_t             live_count_reg, live_count_next;
    link_t             depth_reg, depth_next;
    link_t             init_count_reg, init_count_next;
    logic              init_done_reg, init_done_next;
    logic [DIST_W-1:0] move_cnt_reg, move_cnt_next;
    logic              move_up_reg, move_up_next;
    row_t              sweep_reg, sweep_next;
    row_t              rest_row_reg, rest_row_next;
    logic              qry_ok_reg, qry_ok_next;
    logic              res_error_reg, res_error_next;
    logic              res_present_reg, res_present_next;
    logic              m_valid_reg, m_valid_next;
    row_t              m_cursor_reg, m_cursor_next;
    logic              m_present_reg, m_present_next;
    logic              m_error_reg, m_error_next;

    // memory ports
    logic              prev_we, next_we, live_we, stack_we;
    row_t              prev_waddr, next_waddr, live_waddr, stack_waddr;
    link_t             prev_wdata, next_wdata;
    logic              live_wdata;
    row_t              stack_wdata;
    row_t              link_raddr, live_raddr, stack_raddr;
    link_t             prev_rdata, next_rdata;
    logic              live_rdata;
    row_t              stack_rdata;

    logic              accept;
    logic [DIST_W-1:0] in_dist;
    row_t              in_qrow;
    link_t             nb;
    logic              sweep_last;

    // link, live and stack memories
    rtcdu_ram #(.WIDTH(LINK_W), .DEPTH(MAX_ROWS)) u_prev_ram (
        .clk   (clk),
        .we    (prev_we),
        .waddr (prev_waddr),
        .wdata (prev_wdata),
        .raddr (link_raddr),
        .rdata (prev_rdata)
    );

    rtcdu_ram #(.WIDTH(LINK_W), .DEPTH(MAX_ROWS)) u_next_ram (
        .clk   (clk),
        .we    (next_we),
        .waddr (next_waddr),
        .wdata (next_wdata),
        .raddr (link_raddr),
        .rdata (next_rdata)
    );

    rtcdu_ram #(.WIDTH(1), .DEPTH(MAX_ROWS)) u_live_ram (
        .clk   (clk),
        .we    (live_we),
        .waddr (live_waddr),
        .wdata (live_wdata),
        .raddr (live_raddr),
        .rdata (live_rdata)
    );

    rtcdu_ram #(.WIDTH(ROW_W), .DEPTH(MAX_ROWS)) u_stack_ram (
        .clk   (clk),
        .we    (stack_we),
        .waddr (stack_waddr),
        .wdata (stack_wdata),
        .raddr (stack_raddr),
        .rdata (stack_rdata)
    );

    // handshake and payload
    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid & s_tready;
    assign in_dist  = s_tdata[DIST_W-1:0];
    assign in_qrow  = s_tdata[DIST_W+ROW_W-1:DIST_W];

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = M_DATA_W'({m_present_reg, m_cursor_reg});
    assign m_tuser  = m_error_reg;

    // neighbor on the walk direction and end of init sweep
    assign nb         = move_up_reg ? prev_rdata : next_rdata;
    assign sweep_last = ((LINK_W'(sweep_reg) + LINK_W'(1)) == row_count_reg);

    // sequencer: read, modify and write back the link memories
    always_comb
    begin
        state_next       = state_reg;
        cursor_next      = cursor_reg;
        live_count_next  = live_count_reg;
        depth_next       = depth_reg;
        init_count_next  = init_count_reg;
        init_done_next   = init_done_reg;
        move_cnt_next    = move_cnt_reg;
        move_up_next     = move_up_reg;
        sweep_next       = sweep_reg;
        rest_row_next    = rest_row_reg;
        qry_ok_next      = qry_ok_reg;
        res_error_next   = res_error_reg;
        res_present_next = res_present_reg;
        m_valid_next     = m_valid_reg & ~m_tready;
        m_cursor_next    = m_cursor_reg;
        m_present_next   = m_present_reg;
        m_error_next     = m_error_reg;

        prev_we     = 1'b0;
        next_we     = 1'b0;
        live_we     = 1'b0;
        stack_we    = 1'b0;
        prev_waddr  = sweep_reg;
        next_waddr  = sweep_reg;
        live_waddr  = sweep_reg;
        stack_waddr = depth_reg[ROW_W-1:0];
        prev_wdata  = NO_ROW;
        next_wdata  = NO_ROW;
        live_wdata  = 1'b1;
        stack_wdata = cursor_reg;
        link_raddr  = cursor_reg;
        live_raddr  = in_qrow;
        stack_raddr = depth_reg[ROW_W-1:0] - ROW_W'(1);

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    res_error_next   = 1'b0;
                    res_present_next = 1'b0;
                    case (s_tuser)
                        ACT_INIT:
                        begin
                            if (row_count_reg < LINK_W'(2) ||
                                row_count_reg > LINK_W'(MAX_ROWS) ||
                                LINK_W'(start_row_reg) >= row_count_reg)
                            begin
                                res_error_next = 1'b1;
                                state_next     = ST_OUT;
                            end
                            else
                            begin
                                sweep_next = '0;
                                state_next = ST_INIT;
                            end
                        end
                        ACT_UP, ACT_DOWN:
                        begin
                            move_up_next  = (s_tuser == ACT_UP);
                            move_cnt_next = in_dist;
                            if (live_count_reg == '0)
                            begin
                                res_error_next = 1'b1;
                                state_next     = ST_OUT;
                            end
                            else if (in_dist == '0)
                            begin
                                state_next = ST_OUT;
                            end
                            else
                            begin
                                state_next = ST_MOVE;
                            end
                        end
                        ACT_CUT:
                        begin
                            if (live_count_reg < LINK_W'(2) ||
                                depth_reg >= LINK_W'(MAX_ROWS))
                            begin
                                res_error_next = 1'b1;
                                state_next     = ST_OUT;
                            end
                            else
                            begin
                                state_next = ST_CUT;
                            end
                        end
                        ACT_RESTORE:
                        begin
                            if (depth_reg == '0)
                            begin
                                res_error_next = 1'b1;
                                state_next     = ST_OUT;
                            end
                            else
                            begin
                                depth_next = depth_reg - LINK_W'(1);
                                state_next = ST_RST_STK;
                            end
                        end
                        ACT_QUERY:
                        begin
                            qry_ok_next = init_done_reg &
                                          (LINK_W'(in_qrow) < init_count_reg);
                            state_next  = ST_QUERY;
                        end
                        default:
                        begin
                            res_error_next = 1'b1;
                            state_next     = ST_OUT;
                        end
                    endcase
                end
            end

            // one row of links per cycle
            ST_INIT:
            begin
                prev_we    = 1'b1;
                next_we    = 1'b1;
                live_we    = 1'b1;
                prev_wdata = (sweep_reg == '0) ? NO_ROW : LINK_W'(sweep_reg - ROW_W'(1));
                next_wdata = sweep_last ? NO_ROW : (LINK_W'(sweep_reg) + LINK_W'(1));
                if (sweep_last)
                begin
                    cursor_next     = start_row_reg;
                    depth_next      = '0;
                    live_count_next = row_count_reg;
                    init_count_next = row_count_reg;
                    init_done_next  = 1'b1;
                    state_next      = ST_OUT;
                end
                else
                begin
                    sweep_next = sweep_reg + ROW_W'(1);
                end
            end

            // one link per cycle, read address from the read data
            ST_MOVE:
            begin
                link_raddr = nb[ROW_W-1:0];
                if (nb[ROW_W])
                begin
                    res_error_next = 1'b1;
                    state_next     = ST_OUT;
                end
                else if (move_cnt_reg == DIST_W'(1))
                begin
                    cursor_next = nb[ROW_W-1:0];
                    state_next  = ST_OUT;
                end
                else
                begin
                    move_cnt_next = move_cnt_reg - DIST_W'(1);
                end
            end

            // unlink cursor row and push it
            ST_CUT:
            begin
                next_we     = ~prev_rdata[ROW_W];
                next_waddr  = prev_rdata[ROW_W-1:0];
                next_wdata  = next_rdata;
                prev_we     = ~next_rdata[ROW_W];
                prev_waddr  = next_rdata[ROW_W-1:0];
                prev_wdata  = prev_rdata;
                stack_we    = 1'b1;
                live_we     = 1'b1;
                live_waddr  = cursor_reg;
                live_wdata  = 1'b0;
                depth_next      = depth_reg + LINK_W'(1);
                live_count_next = live_count_reg - LINK_W'(1);
                cursor_next     = next_rdata[ROW_W] ? prev_rdata[ROW_W-1:0]
                                                    : next_rdata[ROW_W-1:0];
                state_next      = ST_OUT;
            end

            // popped row arrives, read its old links
            ST_RST_STK:
            begin
                link_raddr    = stack_rdata;
                rest_row_next = stack_rdata;
                state_next    = ST_RST_LNK;
            end

            // relink popped row between its old neighbors
            ST_RST_LNK:
            begin
                next_we    = ~prev_rdata[ROW_W];
                next_waddr = prev_rdata[ROW_W-1:0];
                next_wdata = LINK_W'(rest_row_reg);
                prev_we    = ~next_rdata[ROW_W];
                prev_waddr = next_rdata[ROW_W-1:0];
                prev_wdata = LINK_W'(rest_row_reg);
                live_we    = 1'b1;
                live_waddr = rest_row_reg;
                live_wdata = 1'b1;
                live_count_next = live_count_reg + LINK_W'(1);
                state_next      = ST_OUT;
            end

            ST_QUERY:
            begin
                res_present_next = qry_ok_reg & live_rdata;
                state_next       = ST_OUT;
            end

            // hand the result to the output register when it is free
            ST_OUT:
            begin
                if (!m_valid_reg || m_tready)
                begin
                    m_valid_next   = 1'b1;
                    m_cursor_next  = cursor_reg;
                    m_present_next = res_present_reg;
                    m_error_next   = res_error_reg;
                    state_next     = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            cursor_reg     <= '0;
            live_count_reg <= '0;
            depth_reg      <= '0;
            init_count_reg <= '0;
            init_done_reg  <= 1'b0;
            m_valid_reg    <= 1'b0;
            row_count_reg  <= LINK_W'(MAX_ROWS);
            start_row_reg  <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            cursor_reg     <= cursor_next;
            live_count_reg <= live_count_next;
            depth_reg      <= depth_next;
            init_count_reg <= init_count_next;
            init_done_reg  <= init_done_next;
            m_valid_reg    <= m_valid_next;
            // configuration writes
            if (cfg_wr_en)
            begin
                case (cfg_addr)
                    CFG_ROW_COUNT: row_count_reg <= cfg_wdata;
                    CFG_START_ROW: start_row_reg <= cfg_wdata[ROW_W-1:0];
                    default:       row_count_reg <= row_count_reg;
                endcase
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        move_cnt_reg    <= move_cnt_next;
        move_up_reg     <= move_up_next;
        sweep_reg       <= sweep_next;
        rest_row_reg    <= rest_row_next;
        qry_ok_reg      <= qry_ok_next;
        res_error_reg   <= res_error_next;
        res_present_reg <= res_present_next;
        m_cursor_reg    <= m_cursor_next;
        m_present_reg   <= m_present_next;
        m_error_reg     <= m_error_next;
    end

    // every row is either live or on the stack between actions
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) |-> (live_count_reg + depth_reg == init_count_reg))
        else $error("live rows and stacked rows do not add up to the table size");

    // a walk in progress always has steps left
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_MOVE) |-> (move_cnt_reg != '0))
        else $error("move walk running with zero steps left");

    // the cursor stays on a linked row while idle
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE && init_done_reg) |->
            (LINK_W'(cursor_reg) < init_count_reg))
        else $error("cursor outside the linked rows");

    // a new result only comes from the result state
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_valid_reg && !$past(m_valid_reg)) |-> ($past(state_reg) == ST_OUT))
        else $error("result loaded outside the result state");

endmodule
